[src/heading_hold_motor_mix_assert.svh]
// ----------------------------------------------------------------------------
// Heading hold motor mix assertion macros
// Shared assertion forms used by the heading hold mixer RTL.
// ----------------------------------------------------------------------------
`ifndef HEADING_HOLD_MOTOR_MIX_ASSERT_SVH
`define HEADING_HOLD_MOTOR_MIX_ASSERT_SVH

// Clocked check, ignored while reset is asserted.
`define HHMM_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define HHMM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/hhmm_pkg.sv]
// ----------------------------------------------------------------------------
// Heading hold motor mix package
// Item types, configuration and state structs, command codes and ladder points.
// ----------------------------------------------------------------------------
`default_nettype none

package hhmm_pkg;

    // command codes
    localparam logic [2:0] ACT_CAPTURE_FWD  = 3'd0;
    localparam logic [2:0] ACT_CAPTURE_BACK = 3'd1;
    localparam logic [2:0] ACT_HOLD         = 3'd2;
    localparam logic [2:0] ACT_VEER_LEFT    = 3'd3;
    localparam logic [2:0] ACT_VEER_RIGHT   = 3'd4;

    // heading wrap, 0.1 deg
    localparam logic signed [12:0] HALF_TURN = 13'sd1800;
    localparam logic signed [12:0] FULL_TURN = 13'sd3600;

    // error -> wanted rate ladder
    localparam logic signed [11:0] ERR_BIG   = 12'sd300;
    localparam logic signed [11:0] ERR_MID   = 12'sd50;
    localparam logic signed [11:0] ERR_SMALL = 12'sd10;
    localparam logic signed [11:0] RATE_BIG   = 12'sd300;
    localparam logic signed [11:0] RATE_MID   = 12'sd100;
    localparam logic signed [11:0] RATE_SMALL = 12'sd10;

    // rate difference -> correction step ladder
    localparam logic signed [17:0] DIFF_BIG   = 18'sd300;
    localparam logic signed [17:0] DIFF_MID   = 18'sd100;
    localparam logic signed [17:0] DIFF_SMALL = 18'sd1;
    localparam logic signed [5:0]  STEP_BIG   = 6'sd30;
    localparam logic signed [5:0]  STEP_MID   = 6'sd15;
    localparam logic signed [5:0]  STEP_SMALL = 6'sd1;

    // configuration register indexes and reset values
    localparam logic [1:0] REG_BASE_SPEED = 2'd0;
    localparam logic [1:0] REG_PWM_LIMIT  = 2'd1;
    localparam logic [1:0] REG_CORR_LIMIT = 2'd2;
    localparam logic [1:0] REG_VEER_RATE  = 2'd3;

    localparam logic [7:0]  BASE_SPEED_RST = 8'd180;
    localparam logic [7:0]  PWM_LIMIT_RST  = 8'd230;
    localparam logic [6:0]  CORR_LIMIT_RST = 7'd70;
    localparam logic [10:0] VEER_RATE_RST  = 11'd700;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [11:0] heading;
        logic signed [15:0] yaw_rate;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         left_pwm;
        logic [7:0]         right_pwm;
        logic signed [7:0]  correction;
        logic signed [11:0] heading_error;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  base_speed;
        logic [7:0]  pwm_limit;
        logic [6:0]  correction_limit;
        logic [10:0] veer_rate;
    } cfg_t;

    typedef struct packed {
        logic signed [11:0] target_heading;
        logic               drive_sign;
        logic signed [7:0]  steer_correction;
    } steer_state_t;

endpackage

`default_nettype wire

[src/heading_hold_motor_mix.sv]
// ----------------------------------------------------------------------------
// Heading hold motor mix
// Heading-hold steering controller and two-wheel PWM mixer.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per control tick (command, heading, yaw rate).
//   m_ channel: one result item per input item (duties, correction, error).
//   cfg_we/cfg_index/cfg_wdata: register writes; the user makes them only while idle,
//   which the block itself does not enforce. An accepted item lands in the input
//   register, the steering update runs from it, and the result register loads
//   when it is free or being read. Throughput is one item per cycle while m_ready
//   stays high; the tracked state (target, drive sign, correction) is written in
//   the same cycle the result register loads, so the next item sees it right away.
//   When m_ready is low the result holds, the input register still fills, and
//   s_ready drops once both are occupied.
//   Reset (aresetn low, synchronous) clears both registers' valid flags, the
//   state to zero/forward, and loads the register defaults
//   (base 180, limit 230, correction limit 70, veer rate 700).
// ----------------------------------------------------------------------------
`default_nettype none

module heading_hold_motor_mix (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  var hhmm_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output hhmm_pkg::out_item_t  m_data,
    input  wire                  cfg_we,
    input  wire  [1:0]           cfg_index,
    input  wire  [10:0]          cfg_wdata
);

    `include "heading_hold_motor_mix_assert.svh"

    hhmm_pkg::cfg_t         cfg_reg;
    hhmm_pkg::steer_state_t state_reg;
    hhmm_pkg::steer_state_t state_next;
    hhmm_pkg::in_item_t     in_reg;
    logic                   in_valid_reg;
    hhmm_pkg::out_item_t    out_reg;
    hhmm_pkg::out_item_t    out_next;
    logic                   out_valid_reg;
    logic                   advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_speed       <= hhmm_pkg::BASE_SPEED_RST;
            cfg_reg.pwm_limit        <= hhmm_pkg::PWM_LIMIT_RST;
            cfg_reg.correction_limit <= hhmm_pkg::CORR_LIMIT_RST;
            cfg_reg.veer_rate        <= hhmm_pkg::VEER_RATE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hhmm_pkg::REG_BASE_SPEED: cfg_reg.base_speed       <= cfg_wdata[7:0];
                hhmm_pkg::REG_PWM_LIMIT:  cfg_reg.pwm_limit        <= cfg_wdata[7:0];
                hhmm_pkg::REG_CORR_LIMIT: cfg_reg.correction_limit <= cfg_wdata[6:0];
                hhmm_pkg::REG_VEER_RATE:  cfg_reg.veer_rate        <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    hhmm_steer u_steer (
        .item   (in_reg),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    `HHMM_ASSERT_CLK(a_advance_loads_result, aclk, aresetn, advance |=> out_valid_reg, "advanced item missing from result register")
    `HHMM_ASSERT_CLK(a_stall_means_full, aclk, aresetn, !s_ready |-> (in_valid_reg && out_valid_reg), "input stalled with a free stage")
    `HHMM_ASSERT_CLK(a_capture_keeps_corr, aclk, aresetn, (advance && (in_reg.action == hhmm_pkg::ACT_CAPTURE_FWD || in_reg.action == hhmm_pkg::ACT_CAPTURE_BACK)) |=> (state_reg.steer_correction == $past(state_reg.steer_correction)), "capture changed correction")
    `HHMM_ASSERT_CLK(a_state_only_on_advance, aclk, aresetn, !$past(advance) |-> $stable(state_reg), "state changed without an item")

endmodule

`default_nettype wire

[src/hhmm_steer.sv]
// ----------------------------------------------------------------------------
// Heading hold steering update
// One tick of the controller: next state and the mixed wheel duties.
// ----------------------------------------------------------------------------
`default_nettype none

module hhmm_steer (
    input  var hhmm_pkg::in_item_t     item,
    input  var hhmm_pkg::cfg_t         cfg,
    input  var hhmm_pkg::steer_state_t cur,
    output hhmm_pkg::steer_state_t     nxt,
    output hhmm_pkg::out_item_t        result
);

    logic               do_step;
    logic signed [11:0] tgt;
    logic signed [12:0] diff;
    logic signed [12:0] err_wide;
    logic signed [11:0] err;
    logic signed [11:0] want;
    logic signed [11:0] veer;
    logic signed [17:0] rate_diff;
    logic signed [5:0]  step;
    logic signed [8:0]  corr_sum;
    logic signed [8:0]  lim;
    logic signed [8:0]  corr_clamp;
    logic signed [8:0]  signed_corr;
    logic signed [9:0]  left_mix;
    logic signed [9:0]  right_mix;
    logic signed [9:0]  duty_max;

    // command decode: capture, then hold/veer step
    always_comb begin
        nxt     = cur;
        do_step = 1'b0;
        veer    = $signed({1'b0, cfg.veer_rate});
        unique case (item.action)
            hhmm_pkg::ACT_CAPTURE_FWD: begin
                nxt.target_heading = item.heading;
                nxt.drive_sign     = 1'b0;
            end
            hhmm_pkg::ACT_CAPTURE_BACK: begin
                nxt.target_heading = item.heading;
                nxt.drive_sign     = 1'b1;
            end
            hhmm_pkg::ACT_HOLD,
            hhmm_pkg::ACT_VEER_LEFT,
            hhmm_pkg::ACT_VEER_RIGHT: begin
                do_step = 1'b1;
            end
            default: begin
                do_step = 1'b0;
            end
        endcase
        if (do_step) begin
            nxt.steer_correction = corr_clamp[7:0];
        end
    end

    // error against the target after this tick; capture takes the new heading
    always_comb begin
        if (item.action == hhmm_pkg::ACT_CAPTURE_FWD ||
            item.action == hhmm_pkg::ACT_CAPTURE_BACK) begin
            tgt = item.heading;
        end else begin
            tgt = cur.target_heading;
        end
        diff = 13'(tgt) - 13'(item.heading);
        if (diff > hhmm_pkg::HALF_TURN) begin
            err_wide = diff - hhmm_pkg::FULL_TURN;
        end else if (diff < -hhmm_pkg::HALF_TURN) begin
            err_wide = diff + hhmm_pkg::FULL_TURN;
        end else begin
            err_wide = diff;
        end
        err = err_wide[11:0];
    end

    // wanted turn rate
    always_comb begin
        if (item.action == hhmm_pkg::ACT_VEER_LEFT) begin
            want = veer;
        end else if (item.action == hhmm_pkg::ACT_VEER_RIGHT) begin
            want = -veer;
        end else if (err > hhmm_pkg::ERR_BIG) begin
            want = hhmm_pkg::RATE_BIG;
        end else if (err > hhmm_pkg::ERR_MID) begin
            want = hhmm_pkg::RATE_MID;
        end else if (err > hhmm_pkg::ERR_SMALL) begin
            want = hhmm_pkg::RATE_SMALL;
        end else if (err > -hhmm_pkg::ERR_SMALL) begin
            want = '0;
        end else if (err > -hhmm_pkg::ERR_MID) begin
            want = -hhmm_pkg::RATE_SMALL;
        end else if (err > -hhmm_pkg::ERR_BIG) begin
            want = -hhmm_pkg::RATE_MID;
        end else begin
            want = -hhmm_pkg::RATE_BIG;
        end
    end

    // correction step and clamp
    always_comb begin
        rate_diff = 18'(want) - 18'(item.yaw_rate);
        if (rate_diff > hhmm_pkg::DIFF_BIG) begin
            step = hhmm_pkg::STEP_BIG;
        end else if (rate_diff > hhmm_pkg::DIFF_MID) begin
            step = hhmm_pkg::STEP_MID;
        end else if (rate_diff > hhmm_pkg::DIFF_SMALL) begin
            step = hhmm_pkg::STEP_SMALL;
        end else if (rate_diff > -hhmm_pkg::DIFF_SMALL) begin
            step = '0;
        end else if (rate_diff > -hhmm_pkg::DIFF_MID) begin
            step = -hhmm_pkg::STEP_SMALL;
        end else if (rate_diff > -hhmm_pkg::DIFF_BIG) begin
            step = -hhmm_pkg::STEP_MID;
        end else begin
            step = -hhmm_pkg::STEP_BIG;
        end
        corr_sum = 9'(cur.steer_correction) + 9'(step);
        lim      = $signed({2'b00, cfg.correction_limit});
        if (corr_sum > lim) begin
            corr_clamp = lim;
        end else if (corr_sum < -lim) begin
            corr_clamp = -lim;
        end else begin
            corr_clamp = corr_sum;
        end
    end

    // wheel mix: correction flips with drive direction
    always_comb begin
        signed_corr = nxt.drive_sign ? -9'(nxt.steer_correction)
                                     : 9'(nxt.steer_correction);
        left_mix  = $signed({2'b00, cfg.base_speed}) - 10'(signed_corr);
        right_mix = $signed({2'b00, cfg.base_speed}) + 10'(signed_corr);
        duty_max  = $signed({2'b00, cfg.pwm_limit});

        if (left_mix < 10'sd0) begin
            result.left_pwm = '0;
        end else if (left_mix > duty_max) begin
            result.left_pwm = cfg.pwm_limit;
        end else begin
            result.left_pwm = left_mix[7:0];
        end
        if (right_mix < 10'sd0) begin
            result.right_pwm = '0;
        end else if (right_mix > duty_max) begin
            result.right_pwm = cfg.pwm_limit;
        end else begin
            result.right_pwm = right_mix[7:0];
        end
        result.correction    = nxt.steer_correction;
        result.heading_error = err;
    end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heading hold motor mix testbench
// Drives command/heading/yaw-rate items through the mixer under random
// stalls on both channels. A scoreboard object tracks target, drive sign and
// correction, predicts each result item, and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 250;
    localparam int HOLDOFF_LEN   = 80;

    class steer_mix_scoreboard;
        hhmm_pkg::cfg_t         regs;
        hhmm_pkg::steer_state_t st;
        hhmm_pkg::out_item_t    expected_mix_q[$];
        int unsigned            mix_errors;

        function new();
            regs       = '{hhmm_pkg::BASE_SPEED_RST, hhmm_pkg::PWM_LIMIT_RST,
                           hhmm_pkg::CORR_LIMIT_RST, hhmm_pkg::VEER_RATE_RST};
            st         = '0;
            mix_errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [10:0] val);
            case (idx)
                hhmm_pkg::REG_BASE_SPEED: regs.base_speed       = val[7:0];
                hhmm_pkg::REG_PWM_LIMIT:  regs.pwm_limit        = val[7:0];
                hhmm_pkg::REG_CORR_LIMIT: regs.correction_limit = val[6:0];
                hhmm_pkg::REG_VEER_RATE:  regs.veer_rate        = val;
            endcase
        endfunction

        // target minus measured, folded once by a full turn
        function int wrapped_error(int hd);
            int e;
            e = int'($signed(st.target_heading));
            e = e - hd;
            if (e > 1800)
                e -= 3600;
            else if (e < -1800)
                e += 3600;
            return e;
        endfunction

        function logic [7:0] duty(int v);
            if (v < 0)
                return '0;
            if (v > int'(regs.pwm_limit))
                return regs.pwm_limit;
            return v[7:0];
        endfunction

        function void note_command(hhmm_pkg::in_item_t it);
            int                  hd, yaw, want, diff, corr, lim, signed_corr;
            bit                  steer;
            hhmm_pkg::out_item_t mix;
            hd    = int'($signed(it.heading));
            yaw   = int'($signed(it.yaw_rate));
            want  = 0;
            steer = 1'b1;
            case (it.action)
                hhmm_pkg::ACT_CAPTURE_FWD, hhmm_pkg::ACT_CAPTURE_BACK: begin
                    st.target_heading = it.heading;
                    st.drive_sign     = (it.action == hhmm_pkg::ACT_CAPTURE_BACK);
                    steer             = 1'b0;
                end
                hhmm_pkg::ACT_HOLD: begin
                    diff = wrapped_error(hd);
                    if (diff > 300)       want = 300;
                    else if (diff > 50)   want = 100;
                    else if (diff > 10)   want = 10;
                    else if (diff > -10)  want = 0;
                    else if (diff > -50)  want = -10;
                    else if (diff > -300) want = -100;
                    else                  want = -300;
                end
                hhmm_pkg::ACT_VEER_LEFT:  want = int'(regs.veer_rate);
                hhmm_pkg::ACT_VEER_RIGHT: want = -int'(regs.veer_rate);
                default:                  steer = 1'b0;
            endcase

            if (steer) begin
                diff = want - yaw;
                corr = int'($signed(st.steer_correction));
                if (diff > 300)       corr += 30;
                else if (diff > 100)  corr += 15;
                else if (diff > 1)    corr += 1;
                else if (diff > -1)   corr += 0;
                else if (diff > -100) corr -= 1;
                else if (diff > -300) corr -= 15;
                else                  corr -= 30;
                lim = int'(regs.correction_limit);
                if (corr > lim)  corr = lim;
                if (corr < -lim) corr = -lim;
                st.steer_correction = corr[7:0];
            end

            corr              = int'($signed(st.steer_correction));
            signed_corr       = st.drive_sign ? -corr : corr;
            mix.left_pwm      = duty(int'(regs.base_speed) - signed_corr);
            mix.right_pwm     = duty(int'(regs.base_speed) + signed_corr);
            mix.correction    = st.steer_correction;
            diff              = wrapped_error(hd);
            mix.heading_error = diff[11:0];
            expected_mix_q.push_back(mix);
        endfunction

        function void check_duties(hhmm_pkg::out_item_t got);
            hhmm_pkg::out_item_t want;
            if (expected_mix_q.size() == 0) begin
                mix_errors++;
                if (mix_errors <= 10)
                    $display("%0t: result item with nothing pending: L=%0d R=%0d C=%0d E=%0d",
                             $time, got.left_pwm, got.right_pwm, got.correction,
                             got.heading_error);
                return;
            end
            want = expected_mix_q.pop_front();
            if (got.left_pwm !== want.left_pwm || got.right_pwm !== want.right_pwm ||
                got.correction !== want.correction ||
                got.heading_error !== want.heading_error) begin
                mix_errors++;
                if (mix_errors <= 10)
                    $display("%0t: mismatch: expected L=%0d R=%0d C=%0d E=%0d,",
                             $time, want.left_pwm, want.right_pwm, want.correction,
                             want.heading_error, " got L=%0d R=%0d C=%0d E=%0d",
                             got.left_pwm, got.right_pwm,
                             got.correction, got.heading_error);
            end
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    hhmm_pkg::in_item_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    hhmm_pkg::out_item_t m_data;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [10:0]         cfg_wdata = '0;

    int tx_idle_pct = 36;
    int rx_idle_pct = 36;
    bit holdoff_req = 1'b0;
    int gen_target  = 0;
    int stall_cycles = 0;

    steer_mix_scoreboard sb = new();

    heading_hold_motor_mix i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side: check at the rising edge, pick ready at the falling edge
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_duties(m_data);
            @(negedge aclk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                hold_left   = HOLDOFF_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic hhmm_pkg::in_item_t steer_item(logic [2:0] act, int hd, int yaw);
        hhmm_pkg::in_item_t it;
        it.action   = act;
        it.heading  = hd[11:0];
        it.yaw_rate = yaw[15:0];
        return it;
    endfunction

    // mostly capture-then-hold sequences near the target, some raw noise
    function automatic hhmm_pkg::in_item_t random_steer_item();
        int         pick, hd, yaw;
        logic [2:0] act;
        pick = $urandom_range(99);
        if (pick < 6)       act = hhmm_pkg::ACT_CAPTURE_FWD;
        else if (pick < 11) act = hhmm_pkg::ACT_CAPTURE_BACK;
        else if (pick < 71) act = hhmm_pkg::ACT_HOLD;
        else if (pick < 82) act = hhmm_pkg::ACT_VEER_LEFT;
        else if (pick < 94) act = hhmm_pkg::ACT_VEER_RIGHT;
        else                act = 3'(hhmm_pkg::ACT_VEER_RIGHT + $urandom_range(1, 3));

        case ($urandom_range(9))
            0, 1:    hd = $urandom;
            2:       hd = gen_target + ($urandom_range(1) ? 1800 : -1800)
                          + $urandom_range(0, 8) - 4;
            default: hd = gen_target + $urandom_range(0, 700) - 350;
        endcase

        case ($urandom_range(9))
            0, 1, 2, 3, 4: yaw = $urandom_range(0, 800) - 400;
            5, 6, 7:       yaw = $urandom_range(0, 6000) - 3000;
            default:       yaw = $urandom;
        endcase

        if (act == hhmm_pkg::ACT_CAPTURE_FWD || act == hhmm_pkg::ACT_CAPTURE_BACK)
            gen_target = int'($signed(hd[11:0]));
        return steer_item(act, hd, yaw);
    endfunction

    task automatic send_item(hhmm_pkg::in_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_command(it);
    endtask

    // cfg_we stays high across consecutive writes
    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic write_config(hhmm_pkg::cfg_t c);
        write_reg(hhmm_pkg::REG_BASE_SPEED, 11'(c.base_speed));
        write_reg(hhmm_pkg::REG_PWM_LIMIT,  11'(c.pwm_limit));
        write_reg(hhmm_pkg::REG_CORR_LIMIT, 11'(c.correction_limit));
        write_reg(hhmm_pkg::REG_VEER_RATE,  c.veer_rate);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_mix_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        hhmm_pkg::cfg_t phase_cfg [6];
        phase_cfg[0] = '{8'd0,   8'd255, 7'd127, 11'd2047};
        phase_cfg[1] = '{8'd255, 8'd0,   7'd0,   11'd0};
        phase_cfg[2] = '{8'd128, 8'd200, 7'd20,  11'd300};
        phase_cfg[3] = '{8'd255, 8'd255, 7'd127, 11'd2000};
        phase_cfg[4] = '{8'd0,   8'd0,   7'd127, 11'd1};
        phase_cfg[5] = '{8'($urandom), 8'($urandom), 7'($urandom),
                         11'($urandom_range(0, 2000))};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, ladder edges, field extremes, wrap
        send_item(steer_item(hhmm_pkg::ACT_CAPTURE_FWD, 0, 0));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, 0, 0));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, 0, -1));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, 0, -2));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, 0, 1));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, 0, -101));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, 0, -301));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, 0, 300));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, -301, 0));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, -51, 0));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, -11, 0));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, 10, 0));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, 50, 0));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, 300, 0));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, -1801, -32768));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, 1801, 32767));
        // heading out past a half turn, back drive
        send_item(steer_item(hhmm_pkg::ACT_CAPTURE_BACK, 2047, 0));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, -2048, -32768));
        send_item(steer_item(hhmm_pkg::ACT_CAPTURE_FWD, -2048, 0));
        send_item(steer_item(hhmm_pkg::ACT_HOLD, 2047, 32767));
        send_item(steer_item(hhmm_pkg::ACT_VEER_LEFT, 0, 0));
        send_item(steer_item(hhmm_pkg::ACT_VEER_RIGHT, 0, 0));
        // undefined action codes leave the state alone
        for (int a = hhmm_pkg::ACT_VEER_RIGHT + 1; a < 8; a++)
            send_item(steer_item(3'(a), $urandom, $urandom));
        gen_target = -2048;

        for (int p = 0; p < 6; p++) begin
            drain();
            write_config(phase_cfg[p]);
            tx_idle_pct = (p == 3) ? 0 : 36;
            rx_idle_pct = (p == 3) ? 0 : 36;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((p == 2 || p == 5) && n == 30)
                    holdoff_req = 1'b1;
                send_item(random_steer_item());
            end
        end

        drain();
        if (sb.mix_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
